### hw/rtl/sdinit_pkg.sv
// ----------------------------------------------------------------------------
// sdinit_pkg
// Shared types, command codes and the control store of the SD init sequencer.
// ----------------------------------------------------------------------------
package sdinit_pkg;

  localparam int UADDR_W = 6;
  localparam int CLK_W   = 20;
  localparam int CAP_W   = 33;

  typedef logic [UADDR_W-1:0] uaddr_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_OK    = 2'd1,
    OP_ERR   = 2'd2,
    OP_NONE  = 2'd3
  } operation_t;

  typedef enum logic [1:0] {
    ACT_CMD  = 2'd0,
    ACT_CLK  = 2'd1,
    ACT_DONE = 2'd2,
    ACT_FAIL = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_CMD55  = 4'd3,
    PH_ACMD41 = 4'd4,
    PH_CMD2   = 4'd5,
    PH_CMD3   = 4'd6,
    PH_CMD9   = 4'd7,
    PH_CMD7   = 4'd8,
    PH_DONE   = 4'd9,
    PH_FAIL   = 4'd10
  } phase_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE      = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NOT_OK    = 3'd2,
    C_NO_ECHO   = 3'd3,
    C_NOT_READY = 3'd4,
    C_NO_HC41   = 3'd5,
    C_ATT_ZERO  = 3'd6
  } cond_t;

  // Datapath operations
  typedef enum logic [3:0] {
    D_NOP      = 4'd0,
    D_CLEAR    = 4'd1,
    D_SET_HC   = 4'd2,
    D_CLR_HC   = 4'd3,
    D_LOAD_ATT = 4'd4,
    D_DEC_ATT  = 4'd5,
    D_CAP_RCA  = 4'd6,
    D_CSD      = 4'd7,
    D_DIV_INIT = 4'd8,
    D_DIV_RUN  = 4'd9
  } dop_t;

  // Argument select
  typedef enum logic [1:0] {
    A_ZERO   = 2'd0,
    A_CMD8   = 2'd1,
    A_ACMD41 = 2'd2,
    A_RCA    = 2'd3
  } asel_t;

  typedef struct packed {
    cond_t       cond;
    uaddr_t      target;
    dop_t        dop;
    logic        emit;
    action_t     act;
    logic [15:0] cmd;
    asel_t       asel;
    logic        last;
    logic        set_ph;
    phase_t      ph;
    logic        halt;
  } uword_t;

  localparam logic [15:0] CW_NONE   = 16'h0000;
  localparam logic [15:0] CW_CMD0   = 16'h0000;
  localparam logic [15:0] CW_CMD8   = 16'h081A;
  localparam logic [15:0] CW_CMD55  = 16'h371A;
  localparam logic [15:0] CW_ACMD41 = 16'h2902;
  localparam logic [15:0] CW_CMD2   = 16'h0209;
  localparam logic [15:0] CW_CMD3   = 16'h031A;
  localparam logic [15:0] CW_CMD9   = 16'h0909;
  localparam logic [15:0] CW_CMD7   = 16'h071B;

  localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
  localparam logic [31:0] ARG_ACMD41 = 32'h00FF_8000;
  localparam logic [31:0] ARG_HCS    = 32'h4000_0000;
  localparam logic [7:0]  ECHO_PAT   = 8'hAA;

  // Program entry points and labels
  localparam uaddr_t U_START   = 6'd0;
  localparam uaddr_t U_CMD0    = 6'd4;
  localparam uaddr_t U_CMD8    = 6'd5;
  localparam uaddr_t U_HC_SET  = 6'd7;
  localparam uaddr_t U_HC_CLR  = 6'd8;
  localparam uaddr_t U_ATT     = 6'd9;
  localparam uaddr_t U_ISS55   = 6'd11;
  localparam uaddr_t U_CMD55   = 6'd12;
  localparam uaddr_t U_ACMD41  = 6'd14;
  localparam uaddr_t U_ISS2    = 6'd17;
  localparam uaddr_t U_USE_ATT = 6'd18;
  localparam uaddr_t U_CMD2    = 6'd21;
  localparam uaddr_t U_CMD3    = 6'd23;
  localparam uaddr_t U_CMD9    = 6'd26;
  localparam uaddr_t U_CMD7    = 6'd29;
  localparam uaddr_t U_FAIL    = 6'd33;

  function automatic uword_t uw(cond_t c, uaddr_t t, dop_t d, logic e, action_t a,
                                logic [15:0] cw, asel_t s, logic l, logic sp,
                                phase_t p, logic h);
    uword_t w;
    w.cond   = c;
    w.target = t;
    w.dop    = d;
    w.emit   = e;
    w.act    = a;
    w.cmd    = cw;
    w.asel   = s;
    w.last   = l;
    w.set_ph = sp;
    w.ph     = p;
    w.halt   = h;
    return w;
  endfunction

  localparam uword_t UW_NOP = '{cond: C_NONE, target: '0, dop: D_NOP, emit: 1'b0,
                                act: ACT_CMD, cmd: CW_NONE, asel: A_ZERO, last: 1'b0,
                                set_ph: 1'b0, ph: PH_IDLE, halt: 1'b1};

  // Control store
  function automatic uword_t ucode(uaddr_t a);
    uword_t w;
    case (a)
      // start: clear card state, slow clock, CMD0
      6'd0:  w = uw(C_NONE, '0, D_CLEAR, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b1, PH_CMD0, 1'b0);
      6'd1:  w = uw(C_NONE, '0, D_DIV_INIT, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd2:  w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CLK, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd3:  w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CMD, CW_CMD0, A_ZERO, 1'b1,
                    1'b0, PH_IDLE, 1'b1);
      // CMD0 done
      6'd4:  w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CMD, CW_CMD8, A_CMD8, 1'b1,
                    1'b1, PH_CMD8, 1'b1);
      // CMD8 done
      6'd5:  w = uw(C_NOT_OK, U_HC_CLR, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd6:  w = uw(C_NO_ECHO, U_ATT, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd7:  w = uw(C_ALWAYS, U_ATT, D_SET_HC, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd8:  w = uw(C_NONE, '0, D_CLR_HC, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd9:  w = uw(C_NONE, '0, D_LOAD_ATT, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd10: w = uw(C_ATT_ZERO, U_FAIL, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd11: w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CMD, CW_CMD55, A_RCA, 1'b1,
                    1'b1, PH_CMD55, 1'b1);
      // CMD55 done
      6'd12: w = uw(C_NOT_OK, U_USE_ATT, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd13: w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CMD, CW_ACMD41, A_ACMD41, 1'b1,
                    1'b1, PH_ACMD41, 1'b1);
      // ACMD41 done
      6'd14: w = uw(C_NOT_READY, U_USE_ATT, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO,
                    1'b0, 1'b0, PH_IDLE, 1'b0);
      6'd15: w = uw(C_NO_HC41, U_ISS2, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd16: w = uw(C_NONE, '0, D_SET_HC, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd17: w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CMD, CW_CMD2, A_ZERO, 1'b1,
                    1'b1, PH_CMD2, 1'b1);
      // one attempt used, retry or give up
      6'd18: w = uw(C_NONE, '0, D_DEC_ATT, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd19: w = uw(C_ATT_ZERO, U_FAIL, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd20: w = uw(C_ALWAYS, U_ISS55, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      // CMD2 done
      6'd21: w = uw(C_NOT_OK, U_FAIL, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd22: w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CMD, CW_CMD3, A_ZERO, 1'b1,
                    1'b1, PH_CMD3, 1'b1);
      // CMD3 done
      6'd23: w = uw(C_NOT_OK, U_FAIL, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd24: w = uw(C_NONE, '0, D_CAP_RCA, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd25: w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CMD, CW_CMD9, A_RCA, 1'b1,
                    1'b1, PH_CMD9, 1'b1);
      // CMD9 done
      6'd26: w = uw(C_NOT_OK, U_FAIL, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd27: w = uw(C_NONE, '0, D_CSD, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd28: w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CMD, CW_CMD7, A_RCA, 1'b1,
                    1'b1, PH_CMD7, 1'b1);
      // CMD7 done: fast clock, done
      6'd29: w = uw(C_NOT_OK, U_FAIL, D_NOP, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd30: w = uw(C_NONE, '0, D_DIV_RUN, 1'b0, ACT_CMD, CW_NONE, A_ZERO, 1'b0,
                    1'b0, PH_IDLE, 1'b0);
      6'd31: w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_CLK, CW_NONE, A_ZERO, 1'b0,
                    1'b1, PH_DONE, 1'b0);
      6'd32: w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_DONE, CW_NONE, A_ZERO, 1'b1,
                    1'b0, PH_IDLE, 1'b1);
      6'd33: w = uw(C_NONE, '0, D_NOP, 1'b1, ACT_FAIL, CW_NONE, A_ZERO, 1'b1,
                    1'b1, PH_FAIL, 1'b1);
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/sdinit_in_if.sv
// ----------------------------------------------------------------------------
// sdinit_in_if
// Event channel into the sequencer: start request or command completion.
// ----------------------------------------------------------------------------
interface sdinit_in_if;
  import sdinit_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] resp_word0;
  logic [31:0] resp_word1;
  logic [31:0] resp_word2;
  logic [31:0] resp_word3;

  modport source (
    output valid, operation, resp_word0, resp_word1, resp_word2, resp_word3,
    input  ready
  );

  modport sink (
    input  valid, operation, resp_word0, resp_word1, resp_word2, resp_word3,
    output ready
  );
endinterface

### hw/rtl/sdinit_out_if.sv
// ----------------------------------------------------------------------------
// sdinit_out_if
// Result channel out of the sequencer: command, clock setting, done or fail.
// ----------------------------------------------------------------------------
interface sdinit_out_if;
  import sdinit_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [15:0]      command_word;
  logic [31:0]      command_argument;
  logic [7:0]       clock_divisor;
  logic [CAP_W-1:0] capacity_blocks;
  logic             high_capacity;
  logic [15:0]      card_address;
  logic             last;

  modport source (
    output valid, action, command_word, command_argument, clock_divisor,
           capacity_blocks, high_capacity, card_address, last,
    input  ready
  );

  modport sink (
    input  valid, action, command_word, command_argument, clock_divisor,
           capacity_blocks, high_capacity, card_address, last,
    output ready
  );
endinterface

### hw/rtl/sdinit_div.sv
// ----------------------------------------------------------------------------
// sdinit_div
// Restoring divider, one quotient bit per cycle; returns base/freq - 1,
// floored at 0 and capped at 255. A zero divisor gives 255.
// ----------------------------------------------------------------------------
module sdinit_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sdinit_pkg::CLK_W-1:0] dividend,
  input  logic [sdinit_pkg::CLK_W-1:0] divisor,
  output logic                         done,
  output logic [7:0]                   result
);
  import sdinit_pkg::*;

  localparam int CNT_W = $clog2(CLK_W);

  logic             busy;
  logic             fin;
  logic [CNT_W-1:0] cnt;
  logic [CLK_W-1:0] rem;
  logic [CLK_W-1:0] quo;
  logic [CLK_W-1:0] dsr;

  logic [CLK_W:0]   trial;
  logic             ge;
  logic [CLK_W:0]   diff;
  logic [CLK_W-1:0] qm1;

  assign trial = {rem, quo[CLK_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};
  assign qm1   = quo - CLK_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(CLK_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
      quo <= {quo[CLK_W-2:0], ge};
    end
    if (fin) begin
      if (quo == '0) begin
        result <= '0;
      end else if (qm1[CLK_W-1:8] != '0) begin
        result <= 8'hFF;
      end else begin
        result <= qm1[7:0];
      end
    end
  end

endmodule

### hw/rtl/sd_card_init_sequencer_top.sv
// ----------------------------------------------------------------------------
// sd_card_init_sequencer_top
// SD card bring-up sequencer: a control store steps a small datapath per event.
// A start and a successful final select event wait on the 20-step clock
// divider before their first result.
// One event at a time; the next event is taken the cycle after its program halts.
// Synchronous reset: idle, card state cleared, registers at their defaults.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer_top (
  input  logic                        clk,
  input  logic                        rst,
  sdinit_in_if.sink                   events,
  sdinit_out_if.source                results,
  input  logic                        write_enable,
  input  logic [1:0]                  write_index,
  input  logic [sdinit_pkg::CLK_W-1:0] write_data
);
  import sdinit_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_INIT = 2'd1;
  localparam logic [1:0] REG_RUN  = 2'd2;
  localparam logic [1:0] REG_ATT  = 2'd3;

  // configuration
  logic [CLK_W-1:0] base_clock_khz;
  logic [CLK_W-1:0] init_clock_khz;
  logic [CLK_W-1:0] run_clock_khz;
  logic [7:0]       max_attempts;

  // sequencer and card state
  seq_state_t       state;
  uaddr_t           pc;
  uword_t           uw_cur;
  phase_t           phase;
  logic [7:0]       attempts_left;
  logic             hc_flag;
  logic [15:0]      rca_reg;
  logic [CAP_W-1:0] capacity_reg;

  // latched event
  logic             op_ok;
  logic [31:0]      w0;
  logic [31:0]      w1;
  logic [31:0]      w2;
  logic [31:0]      w3;

  // result register
  logic             res_valid;
  action_t          res_action;
  logic [15:0]      res_cmd;
  logic [31:0]      res_arg;
  logic [7:0]       res_div;
  logic [CAP_W-1:0] res_cap;
  logic             res_hc;
  logic [15:0]      res_rca;
  logic             res_last;

  // divider
  logic             div_wait;
  logic             div_start;
  logic             div_done;
  logic [7:0]       div_q;
  logic [CLK_W-1:0] div_freq;

  logic             accept;
  logic             disp_ok;
  uaddr_t           disp_pc;
  logic             is_div;
  logic             emit_ok;
  logic             step;
  logic             cond_true;
  logic [31:0]      arg_sel;
  logic [CAP_W-1:0] csd_cap;

  // CSD decode; register bit n holds CSD bit n+8
  logic [21:0]      c2_size;
  logic [22:0]      c2_plus;
  logic [11:0]      c1_size;
  logic [12:0]      c1_plus;
  logic [4:0]       c1_shift;
  logic [36:0]      c1_wide;

  assign uw_cur  = ucode(pc);
  assign accept  = events.valid && events.ready;
  assign is_div  = (uw_cur.dop == D_DIV_INIT) || (uw_cur.dop == D_DIV_RUN);
  assign emit_ok = !res_valid || results.ready;
  assign step    = (state == S_RUN) && !(uw_cur.emit && !emit_ok) && !(is_div && !div_done);

  assign div_start = (state == S_RUN) && is_div && !div_wait;
  assign div_freq  = (uw_cur.dop == D_DIV_INIT) ? init_clock_khz : run_clock_khz;

  always_comb begin
    disp_ok = 1'b0;
    disp_pc = U_START;
    case (operation_t'(events.operation))
      OP_START: disp_ok = 1'b1;
      OP_OK, OP_ERR: begin
        disp_ok = 1'b1;
        case (phase)
          PH_CMD0:   disp_pc = U_CMD0;
          PH_CMD8:   disp_pc = U_CMD8;
          PH_CMD55:  disp_pc = U_CMD55;
          PH_ACMD41: disp_pc = U_ACMD41;
          PH_CMD2:   disp_pc = U_CMD2;
          PH_CMD3:   disp_pc = U_CMD3;
          PH_CMD9:   disp_pc = U_CMD9;
          PH_CMD7:   disp_pc = U_CMD7;
          default:   disp_ok = 1'b0;   // idle, done, fail: ignored
        endcase
      end
      default: disp_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (uw_cur.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_NOT_OK:    cond_true = !op_ok;
      C_NO_ECHO:   cond_true = w0[7:0] != ECHO_PAT;
      C_NOT_READY: cond_true = !(op_ok && w0[31]);
      C_NO_HC41:   cond_true = !w0[30];
      C_ATT_ZERO:  cond_true = attempts_left == 8'd0;
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    case (uw_cur.asel)
      A_CMD8:   arg_sel = ARG_CMD8;
      A_ACMD41: arg_sel = ARG_ACMD41 | (hc_flag ? ARG_HCS : 32'd0);
      A_RCA:    arg_sel = {rca_reg, 16'd0};
      default:  arg_sel = 32'd0;
    endcase
  end

  always_comb begin
    c2_size  = w1[29:8];
    c2_plus  = {1'b0, c2_size} + 23'd1;
    c1_size  = {w2[1:0], w1[31:22]};
    c1_plus  = {1'b0, c1_size} + 13'd1;
    c1_shift = 5'd2 + {2'b00, w1[9:7]} + {1'b0, w2[11:8]};
    c1_wide  = {24'd0, c1_plus} << c1_shift;
    if (w3[23:22] == 2'b01) begin
      csd_cap = {c2_plus, 10'd0};
    end else begin
      csd_cap = {5'd0, c1_wide[36:9]};
    end
  end

  sdinit_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (base_clock_khz),
    .divisor  (div_freq),
    .done     (div_done),
    .result   (div_q)
  );

  // control and card state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_clock_khz <= CLK_W'(100000);
      init_clock_khz <= CLK_W'(400);
      run_clock_khz  <= CLK_W'(25000);
      max_attempts   <= 8'd100;
      state          <= S_IDLE;
      pc             <= U_START;
      phase          <= PH_IDLE;
      attempts_left  <= 8'd0;
      hc_flag        <= 1'b0;
      rca_reg        <= 16'd0;
      capacity_reg   <= '0;
      res_valid      <= 1'b0;
      div_wait       <= 1'b0;
    end else begin
      if (write_enable) begin
        case (write_index)
          REG_BASE: base_clock_khz <= write_data;
          REG_INIT: init_clock_khz <= write_data;
          REG_RUN:  run_clock_khz  <= write_data;
          REG_ATT:  max_attempts   <= write_data[7:0];
          default:  ;
        endcase
      end

      if (results.ready) begin
        res_valid <= 1'b0;
      end

      if (div_start) begin
        div_wait <= 1'b1;
      end else if (div_done) begin
        div_wait <= 1'b0;
      end

      if (accept && disp_ok) begin
        state <= S_RUN;
        pc    <= disp_pc;
      end

      if (step) begin
        case (uw_cur.dop)
          D_CLEAR: begin
            hc_flag       <= 1'b0;
            rca_reg       <= 16'd0;
            capacity_reg  <= '0;
            attempts_left <= 8'd0;
          end
          D_SET_HC:   hc_flag <= 1'b1;
          D_CLR_HC:   hc_flag <= 1'b0;
          D_LOAD_ATT: attempts_left <= max_attempts;
          D_DEC_ATT: begin
            if (attempts_left != 8'd0) begin
              attempts_left <= attempts_left - 8'd1;
            end
          end
          D_CAP_RCA:  rca_reg <= w0[31:16];
          D_CSD:      capacity_reg <= csd_cap;
          default:    ;
        endcase
        if (uw_cur.emit) begin
          res_valid <= 1'b1;
        end
        if (uw_cur.set_ph) begin
          phase <= uw_cur.ph;
        end
        if (uw_cur.halt) begin
          state <= S_IDLE;
        end else if (cond_true) begin
          pc <= uw_cur.target;
        end else begin
          pc <= pc + UADDR_W'(1);
        end
      end
    end
  end

  // event request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_ok <= operation_t'(events.operation) == OP_OK;
      w0    <= events.resp_word0;
      w1    <= events.resp_word1;
      w2    <= events.resp_word2;
      w3    <= events.resp_word3;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step && uw_cur.emit) begin
      res_action <= uw_cur.act;
      res_cmd    <= (uw_cur.act == ACT_CMD) ? uw_cur.cmd : 16'd0;
      res_arg    <= (uw_cur.act == ACT_CMD) ? arg_sel : 32'd0;
      res_div    <= (uw_cur.act == ACT_CLK) ? div_q : 8'd0;
      res_cap    <= capacity_reg;
      res_hc     <= hc_flag;
      res_rca    <= rca_reg;
      res_last   <= uw_cur.last;
    end
  end

  assign events.ready = (state == S_IDLE);

  assign results.valid            = res_valid;
  assign results.action           = res_action;
  assign results.command_word     = res_cmd;
  assign results.command_argument = res_arg;
  assign results.clock_divisor    = res_div;
  assign results.capacity_blocks  = res_cap;
  assign results.high_capacity    = res_hc;
  assign results.card_address     = res_rca;
  assign results.last             = res_last;

endmodule
